FILE: rtl/core/gbs_pkg.sv
// Shared types and constants for the greedy box suppression block.
package gbs_pkg;

    localparam int MAX_KEPT_DEF = 64;
    localparam logic [15:0] THRESH_RESET = 16'd45875;

    // register indexes on the config channel
    localparam logic [7:0] REG_THRESH = 8'd0;
    localparam logic [7:0] REG_MODE   = 8'd1;

    localparam logic [1:0] VERD_KEPT   = 2'd0;
    localparam logic [1:0] VERD_SUPP   = 2'd1;
    localparam logic [1:0] VERD_INVAL  = 2'd2;
    localparam logic [1:0] VERD_FULL   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } gbs_state_t;

endpackage

FILE: rtl/core/greedy_box_suppression_top.sv
// Greedy box suppression: compares each box against the kept table held in memory.
//
// Boxes arrive in priority order; each valid box is checked against every box kept
// so far in the set by a pipelined walk that reads one kept entry per cycle from a
// single-port table. Each walk is followed by a drain of the compare pipeline and
// the write-back of a kept box; invalid boxes and boxes arriving at an empty table
// skip the walk. A new input transfer is taken while the previous result still waits
// on the output. verdict: 0 kept, 1 suppressed, 2 invalid, 3 not kept, table full.
// tlast on input ends a set and clears the table.
module greedy_box_suppression_top
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left, top, right, bottom
    input  logic        s_tuser,   // box_valid
    input  logic        s_tlast,   // last_box
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // kept_total, zero pad
    output logic [1:0]  m_tuser,   // verdict
    output logic        m_tlast,   // set_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_KEPT);

    gbs_state_t state_reg, state_next;

    logic [15:0]   thresh_reg;
    logic          mode_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [63:0]   box_reg;
    logic          bvalid_reg, last_reg;
    logic          supp_reg;
    logic          m_tvalid_reg;
    logic [1:0]    verd_reg;
    logic [CW-1:0] total_reg;
    logic          done_reg;

    logic [63:0] mem [MAX_KEPT];
    logic [63:0] q_reg;
    logic        v1_reg, va_reg, vb_reg, vc_reg, vd_reg;

    logic s_acc, out_free, rd_en, fin_en, wr_en;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = verd_reg;
    assign m_tdata   = {1'b0, 7'(total_reg)};
    assign m_tlast   = done_reg;

    always_comb begin
        state_next = state_reg;
        rd_en      = 1'b0;
        fin_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser && count_reg != '0) state_next = ST_WALK;
                    else state_next = ST_FINISH;
                end
            end
            ST_WALK: begin
                rd_en = 1'b1;
                if (idx_reg == count_reg - CW'(1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!(v1_reg || va_reg || vb_reg || vc_reg || vd_reg)) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    fin_en     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
            mode_reg   <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_THRESH) thresh_reg <= cfg_data;
            else if (cfg_index == REG_MODE) mode_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            box_reg    <= s_tdata;
            bvalid_reg <= s_tuser;
            last_reg   <= s_tlast;
        end
    end

    // walk index
    always_ff @(posedge aclk) begin
        if (s_acc) idx_reg <= '0;
        else if (rd_en) idx_reg <= idx_reg + CW'(1);
    end

    // kept table
    assign wr_en = fin_en && bvalid_reg && !supp_reg && (count_reg < MAXC);
    always_ff @(posedge aclk) begin
        if (wr_en) mem[count_reg[AW-1:0]] <= box_reg;
        if (rd_en) q_reg <= mem[idx_reg[AW-1:0]];
    end

    // compare pipeline
    logic signed [15:0] a0, a1, a2, a3, b0, b1, b2, b3;
    logic signed [17:0] wa_reg, ha_reg, wb_reg, hb_reg, ow_reg, oh_reg;
    logic               skip_a_reg, skip_b_reg, skip_c_reg;
    logic signed [35:0] area_a_reg, area_b_reg, ov_b_reg, ov_c_reg, ov_d_reg;
    logic signed [37:0] den_reg, den_c;
    logic signed [35:0] amin;
    logic signed [54:0] prod_reg, lhs;
    logic               ok_d_reg;

    assign a0 = q_reg[15:0];
    assign a1 = q_reg[31:16];
    assign a2 = q_reg[47:32];
    assign a3 = q_reg[63:48];
    assign b0 = box_reg[15:0];
    assign b1 = box_reg[31:16];
    assign b2 = box_reg[47:32];
    assign b3 = box_reg[63:48];

    assign amin  = (area_a_reg < area_b_reg) ? area_a_reg : area_b_reg;
    assign den_c = mode_reg ? 38'(amin)
                            : 38'(area_a_reg) + 38'(area_b_reg) - 38'(ov_b_reg);
    assign lhs   = {{3{ov_d_reg[35]}}, ov_d_reg, 16'b0};

    always_ff @(posedge aclk) begin
        wa_reg <= 18'(a2) - 18'(a0) + 18'sd16;
        ha_reg <= 18'(a3) - 18'(a1) + 18'sd16;
        wb_reg <= 18'(b2) - 18'(b0) + 18'sd16;
        hb_reg <= 18'(b3) - 18'(b1) + 18'sd16;
        ow_reg <= 18'((a2 < b2) ? a2 : b2) - 18'((a0 > b0) ? a0 : b0) + 18'sd16;
        oh_reg <= 18'((a3 < b3) ? a3 : b3) - 18'((a1 > b1) ? a1 : b1) + 18'sd16;
        skip_a_reg <= (b0 >= a2) || (b1 >= a3) || (b2 <= a0) || (b3 <= a1);

        area_a_reg <= wa_reg * ha_reg;
        area_b_reg <= wb_reg * hb_reg;
        ov_b_reg   <= ow_reg * oh_reg;
        skip_b_reg <= skip_a_reg;

        den_reg    <= den_c;
        ov_c_reg   <= ov_b_reg;
        skip_c_reg <= skip_b_reg;

        prod_reg <= $signed({1'b0, thresh_reg}) * den_reg;
        ov_d_reg <= ov_c_reg;
        ok_d_reg <= !skip_c_reg && !den_reg[37] && (den_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            va_reg <= v1_reg;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) supp_reg <= 1'b0;
        else if (vd_reg && ok_d_reg && (lhs > prod_reg)) supp_reg <= 1'b1;
    end

    // result and count update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fin_en) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (fin_en) begin
                if (last_reg) count_reg <= '0;
                else if (wr_en) count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_en) begin
            done_reg  <= last_reg;
            total_reg <= wr_en ? count_reg + CW'(1) : count_reg;
            if (!bvalid_reg) verd_reg <= VERD_INVAL;
            else if (supp_reg) verd_reg <= VERD_SUPP;
            else if (count_reg < MAXC) verd_reg <= VERD_KEPT;
            else verd_reg <= VERD_FULL;
        end
    end

endmodule

FILE: test/tb_greedy_box_suppression_top.sv
// Self-checking testbench for the greedy box suppression block.
`timescale 1ns / 1ps

module tb_greedy_box_suppression_top
    import gbs_pkg::*;
();

    localparam int KEPT_MAX   = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] bottom;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] left;
    } box_t;

    typedef struct {
        box_t box;
        logic box_valid;
        logic last_box;
    } box_item_t;

    typedef struct {
        logic [1:0] verdict;
        logic [6:0] kept_total;
        logic       set_done;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    greedy_box_suppression_top dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    box_t        kept_table[KEPT_MAX];
    int          kept_cnt;
    logic [15:0] thresh_q;
    logic        min_mode_q;

    box_item_t box_queue[$];
    verdict_t  verdict_queue[$];
    int        mismatches = 0;
    bit        sending = 0;
    int        idle_cycles = 0;

    function automatic bit overlaps_too_much(box_t a, box_t b);
        longint al, at, ar, ab, bl, bt, br, bb, area_a, area_b, ov, den;
        al = a.left; at = a.top; ar = a.right; ab = a.bottom;
        bl = b.left; bt = b.top; br = b.right; bb = b.bottom;
        if (bl >= ar || bt >= ab || br <= al || bb <= at)
            return 0;
        area_a = (ar - al + 16) * (ab - at + 16);
        area_b = (br - bl + 16) * (bb - bt + 16);
        ov = ((ar < br ? ar : br) - (al > bl ? al : bl) + 16) *
             ((ab < bb ? ab : bb) - (at > bt ? at : bt) + 16);
        den = min_mode_q ? (area_a < area_b ? area_a : area_b) : area_a + area_b - ov;
        if (den <= 0)
            return 0;
        return ov * 65536 > longint'(thresh_q) * den;
    endfunction

    function automatic verdict_t predict_verdict(box_item_t it);
        verdict_t r;
        bit supp;
        supp = 0;
        if (!it.box_valid) begin
            r.verdict = VERD_INVAL;
        end else begin
            for (int i = 0; i < kept_cnt && !supp; i++)
                if (overlaps_too_much(kept_table[i], it.box))
                    supp = 1;
            if (supp) begin
                r.verdict = VERD_SUPP;
            end else if (kept_cnt < KEPT_MAX) begin
                kept_table[kept_cnt] = it.box;
                kept_cnt++;
                r.verdict = VERD_KEPT;
            end else begin
                r.verdict = VERD_FULL;
            end
        end
        r.kept_total = kept_cnt[6:0];
        r.set_done = it.last_box;
        if (it.last_box)
            kept_cnt = 0;
        return r;
    endfunction

    // driver: bursts with gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                verdict_queue.push_back(predict_verdict(box_queue.pop_front()));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (sending && box_queue.size() > 0) begin
                    box_item_t nx;
                    nx = box_queue[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= nx.box;
                    s_tuser  <= nx.box_valid;
                    s_tlast  <= nx.last_box;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern + monitor
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30)
                m_tready <= 1'b1;
            else if (stall_phase < 50)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 1) != 0);

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (m_tvalid && m_tready) begin
                if (verdict_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: verdict %0d total %0d done %0d",
                                 m_tuser, m_tdata[6:0], m_tlast);
                end else begin
                    verdict_t e;
                    e = verdict_queue.pop_front();
                    if (e.verdict !== m_tuser || e.kept_total !== m_tdata[6:0] ||
                        m_tdata[7] !== 1'b0 || e.set_done !== m_tlast) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp verdict %0d total %0d done %0d, ",
                                      "got %0d %0d %0d"},
                                     e.verdict, e.kept_total, e.set_done,
                                     m_tuser, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_THRESH)
            thresh_q = val;
        else if (idx == REG_MODE)
            min_mode_q = val[0];
    endtask

    task automatic add_box(input logic signed [15:0] l, t, r, b,
                           input logic v, input logic last);
        box_item_t it;
        it.box.left = l; it.box.top = t; it.box.right = r; it.box.bottom = b;
        it.box_valid = v;
        it.last_box = last;
        box_queue.push_back(it);
    endtask

    // random box, mostly near a cluster so overlaps occur; some are fully random or invalid
    task automatic add_random_box(input int cx, input int cy, input bit last);
        int x, y, w, h;
        case ($urandom_range(0, 9))
            0: add_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom), last);
            1: add_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       1'b0, last);
            default: begin
                x = cx + $urandom_range(0, 200) - 100;
                y = cy + $urandom_range(0, 200) - 100;
                w = $urandom_range(0, 400) - 16;
                h = $urandom_range(0, 400) - 16;
                add_box(16'(x), 16'(y), 16'(x + w), 16'(y + h), 1'b1, last);
            end
        endcase
    endtask

    task automatic run_phase();
        sending = 1;
        while (box_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0)
            @(posedge aclk);
        sending = 0;
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        int sets, n, cx, cy;
        kept_cnt = 0;
        thresh_q = THRESH_RESET;
        min_mode_q = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, identical boxes, touching edges, degenerate, invalid
        add_box(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1, 0);
        add_box(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1, 0);
        add_box(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1, 0);
        add_box(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 1);
        add_box(0, 0, 160, 160, 1, 0);
        add_box(0, 0, 160, 160, 1, 0);
        add_box(160, 0, 320, 160, 1, 0);
        add_box(-160, 0, 0, 160, 1, 0);
        add_box(80, 80, 240, 240, 1, 0);
        add_box(100, 100, 20, 20, 1, 0);
        add_box(10, 10, -40, 150, 1, 0);
        add_box(-16, -16, -16, -16, 1, 0);
        add_box(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 0, 0);
        add_box(0, 0, 160, 160, 1, 1);
        add_box(0, 0, 160, 160, 1, 0);
        for (int i = 0; i < 66; i++)
            add_box(16'(i * 400), 0, 16'(i * 400 + 100), 100, 1, i == 65);
        run_phase();

        write_reg(REG_MODE, 16'd1);
        write_reg(REG_THRESH, 16'd0);
        add_box(0, 0, 160, 160, 1, 0);
        add_box(150, 150, 400, 400, 1, 0);
        add_box(0, 0, 80, 80, 1, 1);
        run_phase();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_THRESH, 16'hffff); write_reg(REG_MODE, 0); end
                1: begin write_reg(REG_THRESH, 16'hffff); write_reg(REG_MODE, 1); end
                2: begin write_reg(REG_THRESH, 16'd32768); write_reg(REG_MODE, 0); end
                3: begin write_reg(REG_THRESH, 16'($urandom)); write_reg(REG_MODE, 1); end
                4: begin write_reg(REG_THRESH, 16'd1); write_reg(REG_MODE, 0); end
                default: begin write_reg(REG_THRESH, THRESH_RESET); write_reg(REG_MODE, 0); end
            endcase
            n = 0;
            while (n < 240) begin
                sets = ($urandom_range(0, 15) == 0) ? 70 : $urandom_range(1, 20);
                cx = $urandom_range(0, 4000) - 2000;
                cy = $urandom_range(0, 4000) - 2000;
                for (int i = 0; i < sets; i++)
                    add_random_box(cx, cy, i == sets - 1);
                n += sets;
            end
            run_phase();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
